/* design/lspq_pkg.sv */
// shared types, codes and constants of the linear scan priority queue
// no dependencies; used by every module of the block
package lspq_pkg;

	localparam int CNT_W         = 5;
	localparam int QUEUE_DEPTH_D = 16;
	localparam int CAP_RESET     = 16;
	localparam int APB_AW        = 3;
	localparam int APB_DW        = 32;

	localparam logic REG_CAPACITY = 1'b0;

	typedef enum logic [1:0] {
		OP_INSERT  = 2'd0,
		OP_EXTRACT = 2'd1,
		OP_CLEAR   = 2'd2,
		OP_NOP     = 2'd3
	} opcode_t;

	typedef enum logic [1:0] {
		ST_DONE      = 2'd0,
		ST_FULL_DROP = 2'd1,
		ST_EMPTY     = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_SCAN_END,
		S_SHIFT
	} state_t;

	typedef struct packed {
		logic [7:0]  prio;
		logic [15:0] job_id;
		logic [7:0]  pages;
	} entry_t;

	typedef struct packed {
		logic imm;
		logic scan_start;
		logic scan_rd;
		logic scan_cmp;
		logic scan_end;
		logic shift_step;
		logic ext_done;
	} cmd_t;

	typedef struct packed {
		logic count_zero;
		logic scan_first;
		logic scan_last;
		logic sh_more;
		logic sh_pend;
	} sts_t;

endpackage

/* design/lspq_regs.sv */
// apb register file: queue capacity register and its saturated value
// depends on lspq_pkg
module lspq_regs #(
	parameter int QUEUE_DEPTH = lspq_pkg::QUEUE_DEPTH_D
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [lspq_pkg::APB_AW-1:0] paddr,
	input  logic [lspq_pkg::APB_DW-1:0] pwdata,
	output logic [lspq_pkg::APB_DW-1:0] prdata,
	output logic                       pready,
	output logic [lspq_pkg::CNT_W-1:0] cap_eff
);

	localparam int CAP_MAX = (QUEUE_DEPTH < 31) ? QUEUE_DEPTH : 31;

	logic [lspq_pkg::CNT_W-1:0] cap_q;
	logic                       sel_cap;

	assign pready  = 1'b1;
	assign sel_cap = (paddr[2] == lspq_pkg::REG_CAPACITY);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= lspq_pkg::CNT_W'(lspq_pkg::CAP_RESET);
		end else if (psel && penable && pwrite && pready && sel_cap) begin
			cap_q <= pwdata[lspq_pkg::CNT_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (sel_cap) begin
			prdata[lspq_pkg::CNT_W-1:0] = cap_q;
		end
	end

	// capacity above the store depth saturates
	assign cap_eff = (cap_q > lspq_pkg::CNT_W'(CAP_MAX)) ? lspq_pkg::CNT_W'(CAP_MAX) : cap_q;

endmodule

/* design/lspq_ctrl.sv */
// controller state machine: sequences scan and shift, owns the handshakes
// depends on lspq_pkg
module lspq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	input  lspq_pkg::opcode_t op,
	input  logic              m_tready,
	input  lspq_pkg::sts_t    sts,
	output logic              s_tready,
	output logic              m_tvalid,
	output lspq_pkg::cmd_t    cmd
);

	lspq_pkg::state_t state_q, state_nx;
	logic             out_valid_q;
	logic             accept;
	logic             shift_done;

	assign s_tready   = (state_q == lspq_pkg::S_IDLE) && (!out_valid_q || m_tready);
	assign accept     = s_tvalid && s_tready;
	assign shift_done = !sts.sh_more && !sts.sh_pend;
	assign m_tvalid   = out_valid_q;

	always_comb begin
		state_nx = state_q;
		case (state_q)
			lspq_pkg::S_IDLE: begin
				if (accept && op == lspq_pkg::OP_EXTRACT && !sts.count_zero) begin
					state_nx = lspq_pkg::S_SCAN;
				end
			end
			lspq_pkg::S_SCAN: begin
				if (sts.scan_last) begin
					state_nx = lspq_pkg::S_SCAN_END;
				end
			end
			lspq_pkg::S_SCAN_END: state_nx = lspq_pkg::S_SHIFT;
			lspq_pkg::S_SHIFT: begin
				if (shift_done) begin
					state_nx = lspq_pkg::S_IDLE;
				end
			end
			default: state_nx = lspq_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			lspq_pkg::S_IDLE: begin
				if (accept) begin
					if (op == lspq_pkg::OP_EXTRACT && !sts.count_zero) begin
						cmd.scan_start = 1'b1;
					end else begin
						cmd.imm = 1'b1;
					end
				end
			end
			lspq_pkg::S_SCAN: begin
				cmd.scan_rd  = 1'b1;
				cmd.scan_cmp = !sts.scan_first;
			end
			lspq_pkg::S_SCAN_END: cmd.scan_end = 1'b1;
			lspq_pkg::S_SHIFT: begin
				cmd.shift_step = !shift_done;
				cmd.ext_done   = shift_done;
			end
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lspq_pkg::S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (cmd.imm || cmd.ext_done) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

/* design/lspq_dp.sv */
// datapath: entry memory, count, scan pointer, best entry, shift pointer, result register
// depends on lspq_pkg
module lspq_dp #(
	parameter int QUEUE_DEPTH = lspq_pkg::QUEUE_DEPTH_D
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  lspq_pkg::cmd_t             cmd,
	input  lspq_pkg::opcode_t          op,
	input  lspq_pkg::entry_t           in_entry,
	input  logic [lspq_pkg::CNT_W-1:0] cap_eff,
	output lspq_pkg::sts_t             sts,
	output lspq_pkg::status_t          res_status,
	output logic                       res_hit,
	output lspq_pkg::entry_t           res_entry,
	output logic [lspq_pkg::CNT_W-1:0] res_count,
	output logic                       res_empty,
	output logic                       res_full
);

	localparam int AW = $clog2(QUEUE_DEPTH);
	localparam int CW = lspq_pkg::CNT_W;

	lspq_pkg::entry_t mem [QUEUE_DEPTH];

	logic [CW-1:0]    count_q;
	logic [CW-1:0]    scan_idx_q;
	logic [CW-1:0]    rd_idx_q;
	logic [CW-1:0]    best_idx_q;
	logic [CW-1:0]    sh_q;
	logic             sh_pend_q;
	lspq_pkg::entry_t rd_data_q;
	lspq_pkg::entry_t best_q;

	logic              take;
	logic              rd_en;
	logic [AW-1:0]     rd_addr;
	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	lspq_pkg::entry_t  wr_data;
	logic              ins_ok;
	logic [CW-1:0]     imm_count;
	lspq_pkg::status_t imm_status;

	assign sts.count_zero = (count_q == '0);
	assign sts.scan_first = (scan_idx_q == '0);
	assign sts.scan_last  = (scan_idx_q == count_q - CW'(1));
	assign sts.sh_more    = (sh_q < count_q);
	assign sts.sh_pend    = sh_pend_q;

	// first entry is always taken, later ones only on strictly higher priority
	assign take   = (rd_idx_q == '0) || (rd_data_q.prio > best_q.prio);
	assign ins_ok = (count_q < cap_eff);

	always_comb begin
		imm_count  = count_q;
		imm_status = lspq_pkg::ST_DONE;
		case (op)
			lspq_pkg::OP_INSERT: begin
				if (ins_ok) begin
					imm_count = count_q + CW'(1);
				end else begin
					imm_status = lspq_pkg::ST_FULL_DROP;
				end
			end
			lspq_pkg::OP_EXTRACT: imm_status = lspq_pkg::ST_EMPTY;
			lspq_pkg::OP_CLEAR:   imm_count  = '0;
			default:              imm_count  = count_q;
		endcase
	end

	// one read port: scan pointer or shift pointer
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = AW'(scan_idx_q);
		if (cmd.scan_rd) begin
			rd_en = 1'b1;
		end else if (cmd.shift_step && sts.sh_more) begin
			rd_en   = 1'b1;
			rd_addr = AW'(sh_q);
		end
	end

	// one write port: append at the tail or move an entry down one place
	always_comb begin
		wr_en   = 1'b0;
		wr_addr = AW'(count_q);
		wr_data = in_entry;
		if (cmd.imm && op == lspq_pkg::OP_INSERT && ins_ok) begin
			wr_en = 1'b1;
		end else if (cmd.shift_step && sh_pend_q) begin
			wr_en   = 1'b1;
			wr_addr = AW'(rd_idx_q - CW'(1));
			wr_data = rd_data_q;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			scan_idx_q <= '0;
			rd_idx_q   <= '0;
			best_idx_q <= '0;
			sh_q       <= '0;
			sh_pend_q  <= 1'b0;
		end else begin
			if (cmd.imm) begin
				count_q <= imm_count;
			end else if (cmd.ext_done) begin
				count_q <= count_q - CW'(1);
			end
			if (cmd.scan_start) begin
				scan_idx_q <= '0;
			end else if (cmd.scan_rd) begin
				scan_idx_q <= scan_idx_q + CW'(1);
				rd_idx_q   <= scan_idx_q;
			end
			if ((cmd.scan_cmp || cmd.scan_end) && take) begin
				best_idx_q <= rd_idx_q;
			end
			if (cmd.scan_end) begin
				sh_q      <= (take ? rd_idx_q : best_idx_q) + CW'(1);
				sh_pend_q <= 1'b0;
			end else if (cmd.shift_step) begin
				if (sts.sh_more) begin
					rd_idx_q  <= sh_q;
					sh_q      <= sh_q + CW'(1);
					sh_pend_q <= 1'b1;
				end else begin
					sh_pend_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if ((cmd.scan_cmp || cmd.scan_end) && take) begin
			best_q <= rd_data_q;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.imm) begin
			res_status <= imm_status;
			res_hit    <= 1'b0;
			res_entry  <= '0;
			res_count  <= imm_count;
			res_empty  <= (imm_count == '0);
			res_full   <= (imm_count >= cap_eff);
		end else if (cmd.ext_done) begin
			res_status <= lspq_pkg::ST_DONE;
			res_hit    <= 1'b1;
			res_entry  <= best_q;
			res_count  <= count_q - CW'(1);
			res_empty  <= (count_q == CW'(1));
			res_full   <= ((count_q - CW'(1)) >= cap_eff);
		end
	end

endmodule

/* design/linear_scan_priority_queue_unit.sv */
// top level of the linear scan priority queue: stream channels, apb port
// depends on lspq_pkg, lspq_regs, lspq_ctrl, lspq_dp
//
// usage
// - s_* channel: one operation per transfer, opcode in s_tuser, job fields in s_tdata
// - m_* channel: exactly one result transfer per operation, in operation order
// - apb port: queue_capacity at byte address 0, read back as written (5 bits)
// - insert, clear and no-op finish in the accepting cycle; the result is
//   offered on m_tvalid in the following cycle
// - extract of n held entries: n scan reads through the single read port, the
//   S_SCAN_END state to settle the winner at index b, then S_SHIFT moves each
//   later entry down one place; the result is registered when the shift ends,
//   and the next transfer can be taken at the earliest while that result is
//   offered, if m_tready is high
// - one operation is in flight at a time; s_tready is high only when the
//   sequencer is idle and the result register is empty or being taken
// - a stalled m_tready holds the result in its register and stops new transfers
// - reset empties the queue (count only, the memory keeps its contents) and
//   sets the capacity to 16; no clearing pass is needed
module linear_scan_priority_queue_unit #(
	parameter int QUEUE_DEPTH = lspq_pkg::QUEUE_DEPTH_D
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [31:0]                 s_tdata,   // entry_priority, entry_job_id, entry_pages
	input  logic [1:0]                  s_tuser,   // opcode
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [39:0]                 m_tdata,   // out_priority, out_job_id, out_pages,
	                                               // entry_count, is_empty, is_full, zero pad
	output logic [2:0]                  m_tuser,   // result_status, out_valid
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [lspq_pkg::APB_AW-1:0] paddr,
	input  logic [lspq_pkg::APB_DW-1:0] pwdata,
	output logic [lspq_pkg::APB_DW-1:0] prdata,
	output logic                        pready
);

	localparam int CAP_MAX = (QUEUE_DEPTH < 31) ? QUEUE_DEPTH : 31;

	lspq_pkg::cmd_t             cmd;
	lspq_pkg::sts_t             sts;
	lspq_pkg::opcode_t          op;
	lspq_pkg::entry_t           in_entry;
	logic [lspq_pkg::CNT_W-1:0] cap_eff;
	lspq_pkg::status_t          res_status;
	logic                       res_hit;
	lspq_pkg::entry_t           res_entry;
	logic [lspq_pkg::CNT_W-1:0] res_count;
	logic                       res_empty;
	logic                       res_full;

	// unpack the input transfer
	assign op              = lspq_pkg::opcode_t'(s_tuser);
	assign in_entry.prio   = s_tdata[7:0];
	assign in_entry.job_id = s_tdata[23:8];
	assign in_entry.pages  = s_tdata[31:24];

	lspq_regs #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.cap_eff(cap_eff)
	);

	// sequencer and handshakes
	lspq_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.op      (op),
		.m_tready(m_tready),
		.sts     (sts),
		.s_tready(s_tready),
		.m_tvalid(m_tvalid),
		.cmd     (cmd)
	);

	// memory, pointers and result register
	lspq_dp #(
		.QUEUE_DEPTH(QUEUE_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.op        (op),
		.in_entry  (in_entry),
		.cap_eff   (cap_eff),
		.sts       (sts),
		.res_status(res_status),
		.res_hit   (res_hit),
		.res_entry (res_entry),
		.res_count (res_count),
		.res_empty (res_empty),
		.res_full  (res_full)
	);

	// pack the result transfer
	assign m_tdata = {1'b0, res_full, res_empty, res_count,
		res_entry.pages, res_entry.job_id, res_entry.prio};
	assign m_tuser = {res_hit, res_status};

	// no new operation while a held result is not being taken
	a_no_accept_over_result: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> (!m_tvalid || m_tready))
		else $error("input taken while result register is blocked");

	// input is closed while an extract is scanning or shifting
	a_closed_while_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.scan_rd || cmd.scan_end || cmd.shift_step) |-> !s_tready)
		else $error("input open during extract");

	// a returned entry always comes with a done status
	a_hit_status: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[2]) |-> (m_tuser[1:0] == lspq_pkg::ST_DONE))
		else $error("returned entry with error status");

	// the reported count never exceeds the largest capacity in effect
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[36:32] <= lspq_pkg::CNT_W'(CAP_MAX)))
		else $error("entry count beyond capacity");

	// an extract result is ready in the cycle after the shift finishes
	a_done_to_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ext_done |=> (m_tvalid && m_tuser[2]))
		else $error("extract result not presented");

endmodule
